// ===== rtl/core/kqt_pkg.sv =====
// Shared types, codes and helpers for the keyed quantity table.
// No dependencies; imported by kqt_cell and keyed_quantity_table.
package kqt_pkg;

	// request kinds
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_UPDATE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EXISTS    = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// request transaction payload
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] part_key;
		logic signed [31:0] amount;
	} kqt_req_t;

	// result transaction payload
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] quantity;
	} kqt_rsp_t;

	// token that walks the cell chain, one cell per cycle
	typedef struct packed {
		logic               valid;
		logic [1:0]         kind;
		logic signed [31:0] key;
		logic signed [31:0] amount;
		logic               hit;
		logic signed [31:0] qty;
	} kqt_tok_t;

	// 32-bit signed add that clamps instead of wrapping
	function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [31:0] s;
		s = a + b;
		if ((a[31] == b[31]) && (s[31] != a[31])) begin
			s = a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/kqt_cell.sv =====
// One table entry: stored key and quantity plus one stage of the token chain.
// Depends on kqt_pkg.
module kqt_cell #(
	parameter int CELL_ID = 0,
	parameter int CNT_W   = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CNT_W-1:0]  count,
	input  kqt_pkg::kqt_tok_t tok_in,
	output kqt_pkg::kqt_tok_t tok_out
);
	import kqt_pkg::*;

	logic signed [31:0] key_q;
	logic signed [31:0] qty_q;
	kqt_tok_t           tok_q;
	kqt_tok_t           tok_nxt;

	logic               occupied;
	logic               match;
	logic               ins;
	logic signed [31:0] sum;

	// entry state versus the passing token
	assign occupied = CNT_W'(CELL_ID) < count;
	assign match    = tok_in.valid && occupied && !tok_in.hit && (key_q == tok_in.key);
	assign ins      = tok_in.valid && (tok_in.kind == KIND_INSERT) && !tok_in.hit
	                  && (CNT_W'(CELL_ID) == count);
	assign sum      = sat_add32(qty_q, tok_in.amount);

	always_comb begin
		tok_nxt = tok_in;
		if (match) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.qty = (tok_in.kind == KIND_UPDATE) ? sum : qty_q;
		end
	end

	// stored record: append on insert, saturating add on update
	always_ff @(posedge clk) begin
		if (ins) begin
			key_q <= tok_in.key;
			qty_q <= tok_in.amount;
		end else if (match && (tok_in.kind == KIND_UPDATE)) begin
			qty_q <= sum;
		end
	end

	// chain stage: token cleared under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/core/keyed_quantity_table.sv =====
// Top level of the keyed quantity table: request intake, cell chain, result.
// Depends on kqt_pkg and kqt_cell.
//
// Usage:
//   A request transaction (kind, part_key, amount) is taken at a rising
//   edge with start high and busy low. Each request gives one result
//   transaction (status, quantity), shown on rsp for exactly one cycle with
//   done high; the receiver cannot stall, so it must take it then.
//   The table is a chain of ENTRIES cells, one record per cell. A request
//   travels the chain one cell per cycle; each occupied cell compares its key,
//   the matching cell answers or applies the saturating update, and on insert
//   the first free cell stores the record.
//   The walk down the chain sets the wait from acceptance to done; busy is
//   high from acceptance until done, so a new request can be taken in the
//   cycle done is shown, and none is taken while one is in the chain.
//   An insert into a full table skips the chain and answers in the cycle
//   after it is taken, without raising busy.
//   Reset clears the entry count, the chain tokens and the result strobe;
//   cell contents are left as they are and are only read once written.
module keyed_quantity_table #(
	parameter int ENTRIES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kqt_pkg::kqt_req_t req,
	output logic              done,
	output kqt_pkg::kqt_rsp_t rsp
);
	import kqt_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	kqt_rsp_t         rsp_q;

	kqt_tok_t         tok [0:ENTRIES];
	logic             accept;
	logic             full_ins;
	kqt_tok_t         exit_tok;

	assign accept   = start && !busy_q;
	assign full_ins = (req.kind == KIND_INSERT) && (cnt_q == CNT_W'(ENTRIES));

	// token launched into the first cell
	assign tok[0] = '{
		valid:  accept && !full_ins,
		kind:   req.kind,
		key:    req.part_key,
		amount: req.amount,
		hit:    1'b0,
		qty:    32'sd0
	};

	// cell chain
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kqt_cell #(
			.CELL_ID (i),
			.CNT_W   (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.count   (cnt_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign exit_tok = tok[ENTRIES];

	// control: busy flag, entry count, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= exit_tok.valid || (accept && full_ins);
			if (exit_tok.valid) begin
				busy_q <= 1'b0;
				if ((exit_tok.kind == KIND_INSERT) && !exit_tok.hit) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (accept && !full_ins) begin
				busy_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (exit_tok.valid) begin
			case (exit_tok.kind)
				KIND_INSERT: begin
					if (exit_tok.hit) begin
						rsp_q.status   <= ST_EXISTS;
						rsp_q.quantity <= '0;
					end else begin
						rsp_q.status   <= ST_OK;
						rsp_q.quantity <= exit_tok.amount;
					end
				end
				KIND_SEARCH, KIND_UPDATE: begin
					if (exit_tok.hit) begin
						rsp_q.status   <= ST_OK;
						rsp_q.quantity <= exit_tok.qty;
					end else begin
						rsp_q.status   <= ST_NOT_FOUND;
						rsp_q.quantity <= '0;
					end
				end
				default: begin
					rsp_q.status   <= ST_NOT_FOUND;
					rsp_q.quantity <= '0;
				end
			endcase
		end else if (accept && full_ins) begin
			rsp_q.status   <= ST_FULL;
			rsp_q.quantity <= '0;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// entry count never passes the table size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("entry count above table size");

	// a chain walk ends with a result strobe
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("busy dropped without a result");

	// a failed request reports zero quantity
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (rsp_q.status != ST_OK)) |-> (rsp_q.quantity == '0))
		else $error("nonzero quantity on failure");

	// a launched request holds the block busy
	a_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !full_ins) |=> busy_q)
		else $error("launched request not marked busy");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for keyed_quantity_table: random and directed requests,
// with every result checked against a behavioral copy of the table held in the bench.
// Depends on kqt_pkg and the keyed_quantity_table RTL.
module tb;
	import kqt_pkg::*;

	localparam int TABLE_DEPTH = 128;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic signed [31:0] QTY_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] QTY_MIN = 32'sh8000_0000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	kqt_req_t req = '0;
	logic     done;
	kqt_rsp_t rsp;

	// shadow copy of the table contents
	logic signed [31:0] shadow_keys [TABLE_DEPTH];
	logic signed [31:0] shadow_qty [TABLE_DEPTH];
	int                 shadow_count = 0;

	kqt_rsp_t pending_rsp [$];
	int       errors = 0;

	keyed_quantity_table #(
		.ENTRIES(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always #1 clk = ~clk;

	// index of the occupied entry holding key, -1 if absent
	function automatic int find_key(input logic signed [31:0] key);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_keys[i] == key) return i;
		end
		return -1;
	endfunction

	// apply one request to the shadow table and give the expected result
	function automatic kqt_rsp_t apply_request(input kqt_req_t r);
		kqt_rsp_t           res;
		int                 hit;
		logic signed [32:0] sum;
		res.status   = ST_NOT_FOUND;
		res.quantity = '0;
		hit = find_key(r.part_key);
		case (r.kind)
			KIND_INSERT: begin
				// full check comes before the key match
				if (shadow_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else if (hit >= 0) begin
					res.status = ST_EXISTS;
				end else begin
					shadow_keys[shadow_count] = r.part_key;
					shadow_qty[shadow_count]  = r.amount;
					shadow_count++;
					res.status   = ST_OK;
					res.quantity = r.amount;
				end
			end
			KIND_SEARCH: begin
				if (hit >= 0) begin
					res.status   = ST_OK;
					res.quantity = shadow_qty[hit];
				end
			end
			KIND_UPDATE: begin
				if (hit >= 0) begin
					sum = {shadow_qty[hit][31], shadow_qty[hit]} + {r.amount[31], r.amount};
					// clamp when the 33-bit sum leaves the 32-bit range
					if (sum[32] != sum[31]) begin
						shadow_qty[hit] = sum[32] ? QTY_MIN : QTY_MAX;
					end else begin
						shadow_qty[hit] = sum[31:0];
					end
					res.status   = ST_OK;
					res.quantity = shadow_qty[hit];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// present one request and hold it until the table takes it
	task automatic send_request(input logic [1:0] kind, input logic signed [31:0] key,
		input logic signed [31:0] amount);
		kqt_req_t r;
		r.kind     = kind;
		r.part_key = key;
		r.amount   = amount;
		req   <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_rsp.push_back(apply_request(r));
	endtask

	// sender idle burst
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending until every outstanding result is back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	// key mostly from the stored set, sometimes fresh or one bit off a stored key
	function automatic logic signed [31:0] pick_key();
		logic signed [31:0] k;
		int                 sel;
		int                 flip;
		sel = $urandom_range(0, 99);
		if (shadow_count == 0 || sel < 25) begin
			k = $urandom;
		end else begin
			k = shadow_keys[$urandom_range(0, shadow_count - 1)];
			if (sel < 40) begin
				flip = $urandom_range(0, 31);
				k[flip] = ~k[flip];
			end
		end
		return k;
	endfunction

	function automatic logic signed [31:0] pick_amount();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 200) - 100;
			1: return $urandom_range(0, 1) ? QTY_MAX - $urandom_range(0, 3)
				: QTY_MIN + $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] fresh_key();
		logic signed [31:0] k;
		do k = $urandom; while (find_key(k) >= 0);
		return k;
	endfunction

	// one random request; inserts are rare enough that the table fills slowly
	task automatic send_random(input int insert_pct);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < insert_pct) begin
			send_request(KIND_INSERT, pick_key(), pick_amount());
		end else if (sel < 95) begin
			send_request($urandom_range(0, 1) ? KIND_SEARCH : KIND_UPDATE, pick_key(),
				pick_amount());
		end else begin
			send_request(KIND_UNUSED, pick_key(), pick_amount());
		end
	endtask

	// empty table, boundary keys and amounts, duplicates, saturation, unused kind
	task automatic test_directed();
		send_request(KIND_SEARCH, 32'sd0, 32'sd0);
		send_request(KIND_UPDATE, 32'sd0, 32'sd1);
		send_request(KIND_UNUSED, 32'sd0, 32'sd0);
		send_request(KIND_INSERT, 32'sd0, 32'sd0);
		send_request(KIND_INSERT, QTY_MIN, QTY_MAX);
		hold_off(3);
		send_request(KIND_INSERT, QTY_MAX, QTY_MIN);
		send_request(KIND_INSERT, -32'sd1, 32'sd5);
		send_request(KIND_INSERT, 32'sd0, 32'sd77);
		send_request(KIND_SEARCH, QTY_MIN, 32'sd0);
		send_request(KIND_SEARCH, QTY_MAX, -32'sd1);
		send_request(KIND_UPDATE, QTY_MIN, 32'sd1);
		send_request(KIND_UPDATE, QTY_MAX, -32'sd1);
		send_request(KIND_UPDATE, 32'sd0, QTY_MIN);
		send_request(KIND_UPDATE, -32'sd1, QTY_MAX);
		send_request(KIND_UPDATE, -32'sd1, 32'sd0);
		send_request(KIND_UPDATE, 32'sd0, -32'sd1);
		drain_results();
		send_request(KIND_UNUSED, -32'sd1, QTY_MIN);
		send_request(KIND_SEARCH, -32'sd1, 32'sd0);
		send_request(KIND_SEARCH, 32'sd1, 32'sd0);
		send_request(KIND_UPDATE, 32'sh4000_0000, 32'sd3);
		send_request(KIND_SEARCH, 32'sd0, 32'sd0);
	endtask

	// mixed traffic in blocks, idle bursts switched on and off per block
	task automatic test_random_mix(input int count);
		bit idle_on;
		idle_on = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) idle_on = $urandom_range(0, 1);
			send_random(shadow_count < TABLE_DEPTH - 16 ? 15 : 2);
			if (idle_on && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 10));
			if (i == count / 2) drain_results();
		end
	endtask

	// grow the table to capacity with fresh keys and some lookups in between
	task automatic test_fill_to_full();
		while (shadow_count < TABLE_DEPTH) begin
			send_request(KIND_INSERT, fresh_key(), pick_amount());
			if ($urandom_range(0, 3) == 0) send_random(0);
			if ($urandom_range(0, 4) == 0) hold_off($urandom_range(1, 10));
		end
	endtask

	// full table, back to back with no idling
	task automatic test_full_table();
		send_request(KIND_INSERT, shadow_keys[0], 32'sd1);
		send_request(KIND_INSERT, fresh_key(), 32'sd2);
		send_request(KIND_INSERT, fresh_key(), QTY_MIN);
		send_request(KIND_INSERT, shadow_keys[TABLE_DEPTH - 1], QTY_MAX);
		send_request(KIND_SEARCH, shadow_keys[TABLE_DEPTH - 1], 32'sd0);
		send_request(KIND_UPDATE, shadow_keys[TABLE_DEPTH - 1], QTY_MAX);
		send_request(KIND_UPDATE, shadow_keys[0], QTY_MIN);
		send_request(KIND_SEARCH, shadow_keys[0], 32'sd0);
		for (int i = 0; i < 40; i++) send_random(20);
	endtask

	// result checker: the receiver never stalls, so every strobe is a transaction
	always @(posedge clk) begin
		kqt_rsp_t exp_rsp;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result status %0d quantity %0d", $time,
					rsp.status, rsp.quantity);
				errors++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp.status !== exp_rsp.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d", $time,
						exp_rsp.status, rsp.status);
					errors++;
				end
				if (rsp.quantity !== exp_rsp.quantity) begin
					$display("%0t: quantity mismatch, expected %0d actual %0d", $time,
						exp_rsp.quantity, rsp.quantity);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(300);
		test_fill_to_full();
		test_full_table();
		drain_results();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_rsp.size());
			errors++;
		end
		if (errors == 0) begin
			$display("[keyed_quantity_table] OK");
		end else begin
			$display("[keyed_quantity_table] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1_500_000;
		$display("%0t: timeout", $time);
		$display("[keyed_quantity_table] ERROR");
		$finish;
	end

endmodule
